>>> src/sign_magnitude_alu_top_macros.svh
// Assertion macros for the sign-magnitude ALU top level.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef SIGN_MAGNITUDE_ALU_TOP_MACROS_SVH
`define SIGN_MAGNITUDE_ALU_TOP_MACROS_SVH

// check prop at every rising clock edge outside reset
`define SMALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define SMALU_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

>>> src/smalu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sign-magnitude ALU.
// No dependencies.
package smalu_pkg;

  localparam int FIELD_W = 64;
  localparam int FUNC_W  = 3;

  localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
  localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
  localparam logic [FUNC_W-1:0] FN_MOD = 3'd4;
  localparam logic [FUNC_W-1:0] FN_GT  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LT  = 3'd6;
  localparam logic [FUNC_W-1:0] FN_EQ  = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              a_neg;
    logic              b_neg;
    logic              b_zero;
  } ctl_t;

endpackage

>>> src/smalu_dly.sv
`timescale 1ns / 1ps
// Enabled shift line of DEPTH registers for data that rides along the pipeline.
// No dependencies.
module smalu_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

>>> src/smalu_mul.sv
`timescale 1ns / 1ps
// Three-stage multiplier: half-width partial products, middle sum, final sum.
// No dependencies.
module smalu_mul #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] lo,
  output logic         ovf
);

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  logic [2*LO-1:0]  p00_r, p00_2_r;
  logic [LO+HI-1:0] p01_r, p10_r;
  logic [2*HI-1:0]  p11_r, p11_2_r;
  logic [W:0]       mid_r;
  logic [2*W-1:0]   full;
  logic [W-1:0]     lo_r;
  logic             ovf_r;

  assign full = {p11_2_r, p00_2_r} + ((2*W)'(mid_r) << LO);

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r   <= a[LO-1:0] * b[LO-1:0];
      p01_r   <= a[LO-1:0] * b[W-1:LO];
      p10_r   <= a[W-1:LO] * b[LO-1:0];
      p11_r   <= a[W-1:LO] * b[W-1:LO];
      mid_r   <= (W+1)'(p01_r) + (W+1)'(p10_r);
      p00_2_r <= p00_r;
      p11_2_r <= p11_r;
      lo_r    <= full[W-1:0];
      ovf_r   <= |full[2*W-1:W];
    end
  end

  assign lo  = lo_r;
  assign ovf = ovf_r;

endmodule

>>> src/smalu_div.sv
`timescale 1ns / 1ps
// Restoring divider unrolled into W registered stages, one quotient bit each.
// No dependencies.
module smalu_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  logic [W-1:0] rem_r [1:W];
  logic [W-1:0] dd_r  [1:W];
  logic [W-1:0] dv_r  [1:W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] rem_in;
    logic [W-1:0] dd_in;
    logic [W-1:0] dv_in;
    logic [W:0]   rs;
    logic [W:0]   diff;
    logic         ge;

    if (k == 0) begin : g_head
      assign rem_in = '0;
      assign dd_in  = a;
      assign dv_in  = b;
    end else begin : g_body
      assign rem_in = rem_r[k];
      assign dd_in  = dd_r[k];
      assign dv_in  = dv_r[k];
    end

    assign rs   = {rem_in, dd_in[W-1]};
    assign diff = rs - {1'b0, dv_in};
    assign ge   = rs >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[W-1:0] : rs[W-1:0];
        dd_r[k+1]  <= {dd_in[W-2:0], ge};
      end
    end

    if (k < W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          dv_r[k+1] <= dv_in;
        end
      end
    end
  end

  assign quo = dd_r[W];
  assign rem = rem_r[W];

endmodule

>>> src/sign_magnitude_alu_top.sv
`timescale 1ns / 1ps
// Top level of the pipelined sign-magnitude ALU.
// Depends on smalu_pkg, smalu_dly, smalu_mul, smalu_div and the macro header.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-----------------------
//   input    | in_func in_a_neg in_a_mag in_b_neg in_b_mag  | in_valid / in_ready
//   result   | out_r_neg out_r_mag out_compare_true         | out_valid / out_ready
//            | out_overflow out_divide_by_zero              |
//
// One beat per cycle while not stalled; every beat passes from the input register through
// the divider's one-bit-per-stage chain to the result register.
// Reset clears all valid bits; payload registers are not reset.
// A stall freezes the whole pipeline; in_ready follows !out_valid || out_ready.
`include "sign_magnitude_alu_top_macros.svh"
module sign_magnitude_alu_top #(
  parameter int MAG_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [smalu_pkg::FUNC_W-1:0]        in_func,
  input  logic                                in_a_neg,
  input  logic [smalu_pkg::FIELD_W-1:0]       in_a_mag,
  input  logic                                in_b_neg,
  input  logic [smalu_pkg::FIELD_W-1:0]       in_b_mag,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_r_neg,
  output logic [smalu_pkg::FIELD_W-1:0]       out_r_mag,
  output logic                                out_compare_true,
  output logic                                out_overflow,
  output logic                                out_divide_by_zero
);

  import smalu_pkg::*;

  localparam int W = MAG_WIDTH;
  localparam int ACW = W + 3;

  logic en;
  logic [W:0] vld_r;

  ctl_t         s0_ctl_r;
  logic [W-1:0] s0_am_r, s0_bm_r;
  logic [W-1:0] am, bm;

  // add / compare
  logic         b_eff;
  logic [W:0]   sum;
  logic [W-1:0] add_rm;
  logic         add_rn, add_ovf, cmp;
  logic         mag_gt, mag_lt, mag_eq;
  logic [ACW-1:0] ac_d, ac_q;

  ctl_t         ctl_q;
  logic [W-1:0] mul_lo, mul_lo_q, quo, rem;
  logic         mul_ovf, mul_ovf_q;

  logic         rn_nxt, cmp_nxt, ovf_nxt, dz_nxt;
  logic [W-1:0] rm_nxt;
  logic         out_valid_r, r_neg_r, cmp_r, ovf_r, dz_r;
  logic [W-1:0] r_mag_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign am = in_a_mag[W-1:0];
  assign bm = in_b_mag[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[W-1:0], in_valid};
      out_valid_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl_r.func   <= in_func;
      s0_ctl_r.a_neg  <= in_a_neg && (|am);
      s0_ctl_r.b_neg  <= in_b_neg && (|bm);
      s0_ctl_r.b_zero <= ~(|bm);
      s0_am_r         <= am;
      s0_bm_r         <= bm;
    end
  end

  assign mag_gt = s0_am_r > s0_bm_r;
  assign mag_lt = s0_am_r < s0_bm_r;
  assign mag_eq = s0_am_r == s0_bm_r;
  assign b_eff  = (s0_ctl_r.func == FN_SUB) ? (!s0_ctl_r.b_neg && !s0_ctl_r.b_zero)
                                            : s0_ctl_r.b_neg;
  assign sum    = {1'b0, s0_am_r} + {1'b0, s0_bm_r};

  always_comb begin
    add_ovf = 1'b0;
    if (s0_ctl_r.a_neg == b_eff) begin
      add_rm  = sum[W-1:0];
      add_ovf = sum[W];
      add_rn  = s0_ctl_r.a_neg;
    end else if (mag_gt) begin
      add_rm = s0_am_r - s0_bm_r;
      add_rn = s0_ctl_r.a_neg;
    end else begin
      add_rm = s0_bm_r - s0_am_r;
      add_rn = b_eff;
    end
    if (add_rm == '0) begin
      add_rn = 1'b0;
    end
  end

  always_comb begin
    case (s0_ctl_r.func)
      FN_GT:   cmp = (s0_ctl_r.a_neg != s0_ctl_r.b_neg) ? !s0_ctl_r.a_neg
                   : (s0_ctl_r.a_neg ? mag_lt : mag_gt);
      FN_LT:   cmp = (s0_ctl_r.a_neg != s0_ctl_r.b_neg) ? s0_ctl_r.a_neg
                   : (s0_ctl_r.a_neg ? mag_gt : mag_lt);
      FN_EQ:   cmp = (s0_ctl_r.a_neg == s0_ctl_r.b_neg) && mag_eq;
      default: cmp = 1'b0;
    endcase
  end

  assign ac_d = {add_rn, add_rm, add_ovf, cmp};

  smalu_dly #(.WIDTH(ACW), .DEPTH(W)) u_ac_dly (
    .clk(clk), .en(en), .d(ac_d), .q(ac_q)
  );

  smalu_dly #(.WIDTH($bits(ctl_t)), .DEPTH(W)) u_ctl_dly (
    .clk(clk), .en(en), .d(s0_ctl_r), .q(ctl_q)
  );

  smalu_mul #(.W(W)) u_mul (
    .clk(clk), .en(en), .a(s0_am_r), .b(s0_bm_r), .lo(mul_lo), .ovf(mul_ovf)
  );

  smalu_dly #(.WIDTH(W + 1), .DEPTH(W - 3)) u_mul_dly (
    .clk(clk), .en(en), .d({mul_ovf, mul_lo}), .q({mul_ovf_q, mul_lo_q})
  );

  smalu_div #(.W(W)) u_div (
    .clk(clk), .en(en), .a(s0_am_r), .b(s0_bm_r), .quo(quo), .rem(rem)
  );

  always_comb begin
    rn_nxt  = 1'b0;
    rm_nxt  = '0;
    cmp_nxt = 1'b0;
    ovf_nxt = 1'b0;
    dz_nxt  = 1'b0;
    case (ctl_q.func) inside
      FN_ADD, FN_SUB: begin
        rn_nxt  = ac_q[ACW-1];
        rm_nxt  = ac_q[W+1:2];
        ovf_nxt = ac_q[1];
      end
      FN_MUL: begin
        rm_nxt  = mul_lo_q;
        ovf_nxt = mul_ovf_q;
        rn_nxt  = (ctl_q.a_neg ^ ctl_q.b_neg) && (|mul_lo_q);
      end
      FN_DIV: begin
        if (ctl_q.b_zero) begin
          dz_nxt = 1'b1;
        end else begin
          rm_nxt = quo;
          rn_nxt = (ctl_q.a_neg ^ ctl_q.b_neg) && (|quo);
        end
      end
      FN_MOD: begin
        if (ctl_q.b_zero) begin
          dz_nxt = 1'b1;
        end else begin
          rm_nxt = rem;
          rn_nxt = ctl_q.a_neg && (|rem);
        end
      end
      default: begin
        cmp_nxt = ac_q[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_neg_r <= rn_nxt;
      r_mag_r <= rm_nxt;
      cmp_r   <= cmp_nxt;
      ovf_r   <= ovf_nxt;
      dz_r    <= dz_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_r_neg          = r_neg_r;
  assign out_r_mag          = FIELD_W'(r_mag_r);
  assign out_compare_true   = cmp_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

  `SMALU_ASSERT(a_ready_rule, in_ready == (!out_valid || out_ready), "in_ready mismatch")
  `SMALU_IMPLY(a_neg_zero, out_valid && out_r_neg, out_r_mag != '0, "negative zero")
  `SMALU_IMPLY(a_dz_clean, out_valid && out_divide_by_zero,
               out_r_mag == '0 && !out_overflow && !out_compare_true, "dz result dirty")
  `SMALU_IMPLY(a_cmp_clean, out_valid && out_compare_true,
               out_r_mag == '0 && !out_overflow && !out_r_neg, "compare result dirty")

endmodule
